FILE: src/bwbx_pkg.sv
// Package with shared constants, operation codes and types for the bit field extractor.
`timescale 1ns / 1ps
package bwbx_pkg;

  // Default number of words in the ring store (a power of two).
  localparam int STORE_WORDS_DEF = 256;

  // Fixed field widths of the request and result ports and of the word offset.
  localparam int OP_W    = 2;
  localparam int INDEX_W = 8;
  localparam int WORD_W  = 32;
  localparam int BITPOS_W = 13;
  localparam int COUNT_W = 6;
  localparam int OFF_W   = 5;

  // Largest number of bits one read request may take.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd32;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_SETPOS = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // Control carried from the address stage to the extract stage.
  typedef struct packed {
    logic                 valid;
    logic [OFF_W-1:0]     off;
    logic [COUNT_W-1:0]   cnt;
  } rd_ctl_t;

endpackage

FILE: src/bwbx_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
module bwbx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  output logic [WIDTH-1:0]         rdata0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata0_r;
  logic [WIDTH-1:0] rdata1_r;

  // Write port and registered reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0_r <= mem[raddr0];
    rdata1_r <= mem[raddr1];
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

FILE: src/bwbx_extract.sv
// Extract stage: byte-swaps two store words into stream order and cuts out the field.
`timescale 1ns / 1ps
module bwbx_extract (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  bwbx_pkg::rd_ctl_t                    ctl,
  input  logic [bwbx_pkg::WORD_W-1:0]          word0,
  input  logic [bwbx_pkg::WORD_W-1:0]          word1,
  output logic                                 out_valid,
  output logic [bwbx_pkg::WORD_W-1:0]          out_field_value
);

  logic [bwbx_pkg::WORD_W-1:0]   sw0;
  logic [bwbx_pkg::WORD_W-1:0]   sw1;
  logic [2*bwbx_pkg::WORD_W-1:0] shifted;
  logic [bwbx_pkg::WORD_W-1:0]   top;
  logic [bwbx_pkg::COUNT_W-1:0]  rsh;
  logic [bwbx_pkg::WORD_W-1:0]   field_nxt;
  logic                          out_valid_r;
  logic [bwbx_pkg::WORD_W-1:0]   field_r;

  // Put both words in stream order, align the position to the top and
  // shift the field down so that it ends at bit 0.
  always_comb begin
    sw0     = {word0[7:0], word0[15:8], word0[23:16], word0[31:24]};
    sw1     = {word1[7:0], word1[15:8], word1[23:16], word1[31:24]};
    shifted = {sw0, sw1} << ctl.off;
    top     = shifted[2*bwbx_pkg::WORD_W-1:bwbx_pkg::WORD_W];
    rsh     = bwbx_pkg::COUNT_MAX - ctl.cnt;
    if (ctl.cnt == '0) begin
      field_nxt = '0;
    end else begin
      field_nxt = top >> rsh;
    end
  end

  // Result register: the strobe is control, the value is payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.valid;
    end
    field_r <= field_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_field_value = field_r;

endmodule

FILE: src/be_word_bit_extractor_core.sv
// Big-endian bit field reader over a ring store of 32-bit words.
// A read's result passes the RAM read and control registers, then the result register.
// Throughput: one request of any kind per cycle; busy stays low, since the
// two store words a read needs come from the two read ports of one RAM.
// Reset clears the bit position and the result strobe; the store is not
// cleared and holds garbage until written. STORE_WORDS must be a power of two (not enforced).
`timescale 1ns / 1ps
module be_word_bit_extractor_core #(
  parameter int STORE_WORDS = bwbx_pkg::STORE_WORDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [bwbx_pkg::OP_W-1:0]       in_op,
  input  logic [bwbx_pkg::INDEX_W-1:0]    in_word_index,
  input  logic [bwbx_pkg::WORD_W-1:0]     in_word_data,
  input  logic [bwbx_pkg::BITPOS_W-1:0]   in_bit_position,
  input  logic [bwbx_pkg::COUNT_W-1:0]    in_bit_count,
  output logic                            out_valid,
  output logic [bwbx_pkg::WORD_W-1:0]     out_field_value
);

  localparam int AW = $clog2(STORE_WORDS);
  localparam int PW = AW + bwbx_pkg::OFF_W;
  localparam int IDX_EXT_W = (AW > bwbx_pkg::INDEX_W) ? AW : bwbx_pkg::INDEX_W;
  localparam int POS_EXT_W = (PW > bwbx_pkg::BITPOS_W) ? PW : bwbx_pkg::BITPOS_W;

  logic                          acc;
  logic                          is_write;
  logic                          is_setpos;
  logic                          is_read;
  logic [IDX_EXT_W-1:0]          idx_ext;
  logic [POS_EXT_W-1:0]          pos_ext;
  logic [bwbx_pkg::COUNT_W-1:0]  cnt_sat;
  logic [PW-1:0]                 pos_r;
  logic [PW-1:0]                 pos_nxt;
  logic [AW-1:0]                 w0_addr;
  logic [AW-1:0]                 w1_addr;
  logic [bwbx_pkg::WORD_W-1:0]   rd0;
  logic [bwbx_pkg::WORD_W-1:0]   rd1;
  bwbx_pkg::rd_ctl_t             ctl_r;
  bwbx_pkg::rd_ctl_t             ctl_nxt;

  // Requests are never held off.
  assign busy = 1'b0;
  assign acc  = start && !busy;

  // Decode the request.
  always_comb begin
    is_write  = 1'b0;
    is_setpos = 1'b0;
    is_read   = 1'b0;
    case (in_op)
      bwbx_pkg::OP_WRITE:  is_write  = acc;
      bwbx_pkg::OP_SETPOS: is_setpos = acc;
      bwbx_pkg::OP_READ:   is_read   = acc;
      default: ;
    endcase
  end

  // Index and position wrap onto the ring; the count saturates at 32.
  assign idx_ext = IDX_EXT_W'(in_word_index);
  assign pos_ext = POS_EXT_W'(in_bit_position);
  assign cnt_sat = (in_bit_count > bwbx_pkg::COUNT_MAX) ? bwbx_pkg::COUNT_MAX : in_bit_count;

  // The two words a read touches: the one at the position and the next one.
  assign w0_addr = pos_r[PW-1:bwbx_pkg::OFF_W];
  assign w1_addr = w0_addr + AW'(1);

  // Bit position update.
  always_comb begin
    pos_nxt = pos_r;
    if (is_setpos) begin
      pos_nxt = pos_ext[PW-1:0];
    end else if (is_read) begin
      pos_nxt = pos_r + PW'(cnt_sat);
    end
  end

  // Control handed to the extract stage along with the RAM read.
  always_comb begin
    ctl_nxt.valid = is_read;
    ctl_nxt.off   = pos_r[bwbx_pkg::OFF_W-1:0];
    ctl_nxt.cnt   = cnt_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      ctl_r.valid <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      ctl_r.valid <= ctl_nxt.valid;
    end
    ctl_r.off <= ctl_nxt.off;
    ctl_r.cnt <= ctl_nxt.cnt;
  end

  // Word store: written by write requests, read at two addresses per read.
  bwbx_ram #(
    .WIDTH (bwbx_pkg::WORD_W),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk    (clk),
    .we     (is_write),
    .waddr  (idx_ext[AW-1:0]),
    .wdata  (in_word_data),
    .raddr0 (w0_addr),
    .rdata0 (rd0),
    .raddr1 (w1_addr),
    .rdata1 (rd1)
  );

  bwbx_extract u_extract (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl_r),
    .word0           (rd0),
    .word1           (rd1),
    .out_valid       (out_valid),
    .out_field_value (out_field_value)
  );

  // A result strobe is only raised for a read request held in the control register ctl_r.
  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(ctl_r.valid))
    else $error("result strobe without a read request in flight");

  // A zero-count read returns zero.
  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r.valid && ctl_r.cnt == '0) |=> (out_valid && out_field_value == '0))
    else $error("zero-count read gave a nonzero field");

  // A zero-count read leaves the position where it was.
  a_zero_keeps_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (is_read && in_bit_count == '0) |=> $stable(pos_r))
    else $error("zero-count read moved the bit position");

  // Write requests never produce a result stage entry.
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    is_write |=> !ctl_r.valid)
    else $error("write request started a read");

endmodule
